@@ hdl/japs_pkg.sv @@
// japs_pkg: types, codes and default constants for the joystick average
// position stepper. No dependencies; used by joystick_average_position_stepper.
`timescale 1ns / 1ps

package japs_pkg;

  // field widths
  localparam int SAMPLE_W = 12;
  localparam int POS_W    = 8;
  localparam int DIR_W    = 2;
  localparam int CFG_W    = 12;
  localparam int CFG_IDX_W = 2;

  // default averaging window
  localparam int DEFAULT_WINDOW = 16;

  // register reset values
  localparam logic [SAMPLE_W-1:0] HIGH_THRESHOLD_RST = 12'd3500;
  localparam logic [SAMPLE_W-1:0] LOW_THRESHOLD_RST  = 12'd500;
  localparam logic [POS_W-1:0]    MAX_POSITION_RST   = 8'd180;

  // largest average
  localparam logic [SAMPLE_W-1:0] AVG_MAX = 12'hFFF;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_POSITION   = 2'd2;

  // item kinds
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_STEP   = 1'b1;

  // direction codes
  localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
  localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

  typedef struct packed {
    logic                mode;
    logic [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] filtered_value;
    logic [POS_W-1:0]    position;
    logic [DIR_W-1:0]    direction;
  } out_item_t;

endpackage

@@ hdl/joystick_average_position_stepper.sv @@
// Joystick moving-average filter with threshold position stepper.
// Depends on japs_pkg and japs_ram.
`timescale 1ns / 1ps
//
// Usage
//   in_*  : valid/ready request channel, one in_item_t per request. A sample
//           request (mode 0) adds a 12-bit reading to a moving average over
//           the last WINDOW readings; a step request (mode 1) compares the
//           current average with the thresholds and moves the position by one.
//   out_* : valid/ready channel, exactly one out_item_t per input request
//           with the average, the position and the step direction.
//   cfg_* : write-only register port (high_threshold, low_threshold,
//           max_position), written while the block is idle.
// Timing
//   One request per cycle sustained while out_* is not stalled. A result is
//   registered into out_data, or into the skid entry while out_* is held.
//   The rate is set by the update of the running sum, whose oldest ring
//   entry is read ahead, registered, from the ring RAM at the next pointer.
// Reset
//   rst clears the sum, pointer, average, position and fill flag; no
//   clearing pass is needed, entries not yet written count as zero.
// Stall
//   A two-entry output buffer lets one more request in while a result
//   waits; with both entries full in_ready drops until out_ready.

module joystick_average_position_stepper #(
  parameter int WINDOW = japs_pkg::DEFAULT_WINDOW
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  japs_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output japs_pkg::out_item_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [japs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [japs_pkg::CFG_W-1:0]           cfg_data
);

  import japs_pkg::*;

  localparam int PTR_W = $clog2(WINDOW);
  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);
  localparam int SHIFT = $clog2(WINDOW + 1) - 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);

  // configuration
  logic [SAMPLE_W-1:0] high_threshold;
  logic [SAMPLE_W-1:0] low_threshold;
  logic [POS_W-1:0]    max_position;

  // filter and stepper state
  logic [PTR_W-1:0]    ring_pointer;
  logic [PTR_W-1:0]    ring_pointer_next;
  logic                ring_full;
  logic [SUM_W-1:0]    running_sum;
  logic [SUM_W-1:0]    running_sum_next;
  logic [SAMPLE_W-1:0] average_reg;
  logic [SAMPLE_W-1:0] average_next;
  logic [POS_W-1:0]    position_reg;
  logic [POS_W-1:0]    position_next;
  logic [DIR_W-1:0]    direction;

  // output buffer
  logic      skid_valid;
  out_item_t skid_data;
  out_item_t result;

  logic [SAMPLE_W-1:0] ram_rdata;
  logic [SAMPLE_W-1:0] oldest;
  logic [SUM_W-1:0]    shifted;
  logic                in_fire;
  logic                sample_fire;
  logic                out_take;

  assign in_ready    = !skid_valid;
  assign in_fire     = in_valid && in_ready;
  assign sample_fire = in_fire && (in_data.mode == MODE_SAMPLE);
  assign out_take    = out_valid && out_ready;

  // pointer advance; the RAM reads ahead at the next pointer
  always_comb begin
    ring_pointer_next = ring_pointer;
    if (sample_fire) begin
      ring_pointer_next = (ring_pointer == PTR_LAST) ? '0 : ring_pointer + 1'b1;
    end
  end

  japs_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (sample_fire),
    .waddr (ring_pointer),
    .wdata (in_data.sample),
    .raddr (ring_pointer_next),
    .rdata (ram_rdata)
  );

  // entries before the first wrap have never been written: they count as zero
  assign oldest = ring_full ? ram_rdata : '0;

  // running sum and average
  always_comb begin
    running_sum_next = running_sum - SUM_W'(oldest) + SUM_W'(in_data.sample);
    shifted          = running_sum_next >> SHIFT;
    average_next     = (shifted > SUM_W'(AVG_MAX)) ? AVG_MAX : shifted[SAMPLE_W-1:0];
  end

  // threshold stepper
  always_comb begin
    position_next = position_reg;
    direction     = DIR_NONE;
    if (average_reg > high_threshold) begin
      direction     = DIR_UP;
      position_next = (position_reg >= max_position) ? max_position
                                                     : position_reg + 1'b1;
    end else if (average_reg < low_threshold) begin
      direction = DIR_DOWN;
      if (position_reg != '0) begin
        position_next = position_reg - 1'b1;
      end
    end
  end

  // result of the request being accepted
  always_comb begin
    if (in_data.mode == MODE_SAMPLE) begin
      result.filtered_value = average_next;
      result.position       = position_reg;
      result.direction      = DIR_NONE;
    end else begin
      result.filtered_value = average_reg;
      result.position       = position_next;
      result.direction      = direction;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      high_threshold <= HIGH_THRESHOLD_RST;
      low_threshold  <= LOW_THRESHOLD_RST;
      max_position   <= MAX_POSITION_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HIGH_THRESHOLD: high_threshold <= cfg_data[SAMPLE_W-1:0];
        CFG_LOW_THRESHOLD:  low_threshold  <= cfg_data[SAMPLE_W-1:0];
        CFG_MAX_POSITION:   max_position   <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // filter and stepper state update
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_pointer <= '0;
      ring_full    <= 1'b0;
      running_sum  <= '0;
      average_reg  <= '0;
      position_reg <= '0;
    end else if (in_fire) begin
      if (in_data.mode == MODE_SAMPLE) begin
        ring_pointer <= ring_pointer_next;
        running_sum  <= running_sum_next;
        average_reg  <= average_next;
        if (ring_pointer == PTR_LAST) begin
          ring_full <= 1'b1;
        end
      end else begin
        position_reg <= position_next;
      end
    end
  end

  // two-entry output buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (in_fire) begin
      if (!out_valid || out_take) begin
        out_valid <= 1'b1;
        out_data  <= result;
      end else begin
        skid_valid <= 1'b1;
        skid_data  <= result;
      end
    end else if (out_take) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // a buffered result always sits behind a visible one
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without an output entry");

  // the ring only counts as full after the pointer wraps
  a_full_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !ring_full)
    else $error("ring marked full right after reset");

  // a sample at the last slot wraps the pointer and fills the ring
  a_pointer_wrap: assert property (@(posedge clk) disable iff (rst)
    (sample_fire && ring_pointer == PTR_LAST) |=> (ring_pointer == '0 && ring_full))
    else $error("ring pointer did not wrap");

  // a step request leaves the filter state alone
  a_step_keeps_sum: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_data.mode == MODE_STEP) |=>
      ($stable(running_sum) && $stable(ring_pointer)))
    else $error("step request changed the filter state");

  // a sample request never moves the position
  a_sample_keeps_pos: assert property (@(posedge clk) disable iff (rst)
    sample_fire |=> $stable(position_reg))
    else $error("sample request moved the position");
`endif

endmodule

@@ hdl/japs_ram.sv @@
// japs_ram: generic simple dual-port RAM, one write and one registered read
// port. No dependencies.
`timescale 1ns / 1ps

module japs_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
